// ===== rtl/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 14;
	localparam int OUT_W           = 16;
	localparam int NUM_COORDS      = 9;
	localparam int NUM_AXES        = 3;

endpackage

// ===== rtl/tun_isqrt.sv =====
// ----------------------------------------------------------------------------
// tun_isqrt
// Pipelined floor square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module tun_isqrt #(
	parameter int SW     = 68,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SW-1:0]     in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [SW/2-1:0]   out_root,
	output logic [SIDE_W-1:0] out_side
);
	import tun_pkg::*;

	localparam int RW   = SW / 2;
	localparam int RMW  = RW + 1;
	localparam int CURW = RMW + 2;

	logic [RMW-1:0]    rem_s  [0:RW-1];
	logic [RW-1:0]     root_s [0:RW-1];
	logic [SW-1:0]     rad_s  [0:RW-1];
	logic [SIDE_W-1:0] side_s [0:RW-1];
	logic              vld_s  [0:RW-1];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RMW-1:0]    rem_p;
		logic [RW-1:0]     root_p;
		logic [SW-1:0]     rad_p;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;
		logic [CURW-1:0]   cur;
		logic [CURW-1:0]   trial;
		logic [CURW-1:0]   diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = in_rad;
			assign side_p = in_side;
			assign vld_p  = in_valid;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign cur   = {rem_p, rad_p[SW-1 -: 2]};
		assign trial = {{(CURW-RW-2){1'b0}}, root_p, 2'b01};
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[RMW-1:0] : cur[RMW-1:0];
				root_s[k] <= {root_p[RW-2:0], ge};
				rad_s[k]  <= {rad_p[SW-3:0], 2'b00};
				side_s[k] <= side_p;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

// ===== rtl/tun_div.sv =====
// ----------------------------------------------------------------------------
// tun_div
// Pipelined restoring divider, three components by one shared divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module tun_div #(
	parameter int RW = 35,
	parameter int AW = 34,
	parameter int QB = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [RW-1:0]                      in_m,
	input  logic [tun_pkg::NUM_AXES-1:0][AW-1:0] in_abs,
	input  logic [tun_pkg::NUM_AXES-1:0]       in_neg,
	input  logic                               in_deg,
	output logic                               out_valid,
	output logic [tun_pkg::NUM_AXES-1:0][QB-1:0] out_q,
	output logic [tun_pkg::NUM_AXES-1:0]       out_neg,
	output logic                               out_deg
);
	import tun_pkg::*;

	localparam int DW = RW + 1;

	logic [NUM_AXES-1:0][DW-1:0] r_s   [0:QB-1];
	logic [NUM_AXES-1:0][QB-1:0] q_s   [0:QB-1];
	logic [RW-1:0]               m_s   [0:QB-1];
	logic [NUM_AXES-1:0]         neg_s [0:QB-1];
	logic                        deg_s [0:QB-1];
	logic                        vld_s [0:QB-1];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [NUM_AXES-1:0][DW-1:0] r_p;
		logic [NUM_AXES-1:0][QB-1:0] q_p;
		logic [RW-1:0]               m_p;
		logic [NUM_AXES-1:0]         neg_p;
		logic                        deg_p;
		logic                        vld_p;
		logic [NUM_AXES-1:0][DW-1:0] r_n;
		logic [NUM_AXES-1:0][QB-1:0] q_n;

		if (k == 0) begin : g_first
			for (genvar c = 0; c < NUM_AXES; c++) begin : g_init
				assign r_p[c] = DW'(in_abs[c]);
				assign q_p[c] = '0;
			end
			assign m_p   = in_m;
			assign neg_p = in_neg;
			assign deg_p = in_deg;
			assign vld_p = in_valid;
		end else begin : g_next
			assign r_p   = r_s[k-1];
			assign q_p   = q_s[k-1];
			assign m_p   = m_s[k-1];
			assign neg_p = neg_s[k-1];
			assign deg_p = deg_s[k-1];
			assign vld_p = vld_s[k-1];
		end

		for (genvar c = 0; c < NUM_AXES; c++) begin : g_axis
			logic [DW-1:0] val;
			logic          ge;
			if (k == 0) begin : g_noshift
				assign val = r_p[c];
			end else begin : g_shift
				assign val = {r_p[c][DW-2:0], 1'b0};
			end
			assign ge     = val >= {1'b0, m_p};
			assign r_n[c] = ge ? (val - {1'b0, m_p}) : val;
			assign q_n[c] = {q_p[c][QB-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]   <= r_n;
				q_s[k]   <= q_n;
				m_s[k]   <= m_p;
				neg_s[k] <= neg_p;
				deg_s[k] <= deg_p;
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign out_q     = q_s[QB-1];
	assign out_neg   = neg_s[QB-1];
	assign out_deg   = deg_s[QB-1];

endmodule

// ===== rtl/triangle_unit_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a counter-clockwise triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one triangle per cycle unless the output stalls, and returns one
// item per triangle, in order. The square root has one stage per root bit,
// RW = 2*COORD_WIDTH + 3, and the divider one stage per quotient bit,
// QB = NORMAL_FRAC_BITS + 1. The whole pipeline advances together and
// holds while a finished item waits on m_tready. A zero-area triangle gives
// (0, 0, 1.0) with the degenerate flag in m_tuser.
module triangle_unit_normal #(
	parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
	input  logic [((tun_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// normal_x, normal_y, normal_z
	output logic [3*tun_pkg::OUT_W-1:0] m_tdata,
	// degenerate
	output logic [0:0] m_tuser
);
	import tun_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int EW     = CW + 1;
	localparam int PW     = 2 * EW;
	localparam int NW     = PW + 1;
	localparam int AW     = 2 * CW + 2;
	localparam int SW     = 2 * AW + 2;
	localparam int RW     = SW / 2;
	localparam int QB     = NORMAL_FRAC_BITS + 1;
	localparam int QX     = QB + OUT_W;
	localparam int SIDE_W = NUM_AXES * (AW + 1) + 1;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [CW-1:0] crd [0:NUM_COORDS-1];
	for (genvar i = 0; i < NUM_COORDS; i++) begin : g_unpack
		assign crd[i] = s_tdata[i*CW +: CW];
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [EW-1:0] e1_s1 [0:NUM_AXES-1];
	logic signed [EW-1:0] e2_s1 [0:NUM_AXES-1];
	logic signed [PW-1:0] p_s2  [0:5];
	logic [AW-1:0]        abs_s3 [0:NUM_AXES-1];
	logic [NUM_AXES-1:0]  neg_s3, neg_s4, neg_s5;
	logic                 deg_s3, deg_s4, deg_s5;
	logic [AW-1:0]        abs_s4 [0:NUM_AXES-1];
	logic [AW-1:0]        abs_s5 [0:NUM_AXES-1];
	logic [2*AW-1:0]      sq_s4  [0:NUM_AXES-1];
	logic [SW-1:0]        sum_s5;

	logic signed [NW-1:0] n_c   [0:NUM_AXES-1];
	logic [NW-1:0]        nabs_c [0:NUM_AXES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis
		assign n_c[j]    = NW'(p_s2[2*j]) - NW'(p_s2[2*j+1]);
		assign nabs_c[j] = n_c[j][NW-1] ? (-n_c[j]) : n_c[j];

		always_ff @(posedge clk) begin
			if (en) begin
				e1_s1[j]  <= {crd[3+j][CW-1], crd[3+j]} - {crd[j][CW-1], crd[j]};
				e2_s1[j]  <= {crd[6+j][CW-1], crd[6+j]} - {crd[j][CW-1], crd[j]};
				abs_s3[j] <= nabs_c[j][AW-1:0];
				sq_s4[j]  <= (2*AW)'(abs_s3[j]) * (2*AW)'(abs_s3[j]);
				abs_s4[j] <= abs_s3[j];
				abs_s5[j] <= abs_s4[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			neg_s3  <= {n_c[2][NW-1], n_c[1][NW-1], n_c[0][NW-1]};
			deg_s3  <= (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);
			neg_s4  <= neg_s3;
			deg_s4  <= deg_s3;
			sum_s5  <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			neg_s5  <= neg_s4;
			deg_s5  <= deg_s4;
		end
	end

	logic [SIDE_W-1:0] side_in, side_out;
	logic              sq_valid;
	logic [RW-1:0]     root;

	assign side_in = {deg_s5, neg_s5, abs_s5[2], abs_s5[1], abs_s5[0]};

	tun_isqrt #(
		.SW     (SW),
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_rad    (sum_s5),
		.in_side   (side_in),
		.out_valid (sq_valid),
		.out_root  (root),
		.out_side  (side_out)
	);

	logic [NUM_AXES-1:0][AW-1:0] div_abs;
	logic [NUM_AXES-1:0]         div_neg_in;
	logic                        div_deg_in;
	logic                        div_valid;
	logic [NUM_AXES-1:0][QB-1:0] div_q;
	logic [NUM_AXES-1:0]         div_neg;
	logic                        div_deg;

	assign {div_deg_in, div_neg_in, div_abs} = side_out;

	tun_div #(
		.RW (RW),
		.AW (AW),
		.QB (QB)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_m      (root),
		.in_abs    (div_abs),
		.in_neg    (div_neg_in),
		.in_deg    (div_deg_in),
		.out_valid (div_valid),
		.out_q     (div_q),
		.out_neg   (div_neg),
		.out_deg   (div_deg)
	);

	logic [NUM_AXES-1:0][OUT_W-1:0] comp_c;
	logic [QX-1:0]                  one_c;
	assign one_c = QX'(1) << NORMAL_FRAC_BITS;

	for (genvar j = 0; j < NUM_AXES; j++) begin : g_fmt
		logic [QX-1:0] qx;
		logic [QX-1:0] sv;
		assign qx = QX'(div_q[j]);
		assign sv = div_neg[j] ? (-qx) : qx;
		if (j == NUM_AXES - 1) begin : g_z
			assign comp_c[j] = div_deg ? one_c[OUT_W-1:0] : sv[OUT_W-1:0];
		end else begin : g_xy
			assign comp_c[j] = div_deg ? '0 : sv[OUT_W-1:0];
		end
	end

	logic                           vout_q;
	logic [NUM_AXES-1:0][OUT_W-1:0] norm_q;
	logic                           deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_q <= 1'b0;
		end else if (en) begin
			vout_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_q <= comp_c;
			deg_q  <= div_deg;
		end
	end

	assign m_tvalid = vout_q;
	assign m_tdata  = norm_q;
	assign m_tuser  = deg_q;

endmodule

// ===== rtl/tun_check.sv =====
// ----------------------------------------------------------------------------
// tun_check
// Port-level checks for triangle_unit_normal, bound to the top level.
// ----------------------------------------------------------------------------
module tun_check #(
	parameter int NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [3*tun_pkg::OUT_W-1:0] m_tdata,
	input logic [0:0]                  m_tuser
);
	import tun_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with free output");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[2*OUT_W-1:0] == '0 &&
			m_tdata[3*OUT_W-1:2*OUT_W] == OUT_W'(1 << NORMAL_FRAC_BITS))
		else $error("degenerate item not +z");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready))
		else $error("output appeared during stall");

endmodule

bind triangle_unit_normal tun_check #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_tun_check (.*);
